// File: rtl/assert_macros.svh
// Assertion macros shared by the replay check RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge out of reset
`define PFRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define PFRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/pfrc_pkg.sv
// Shared types and codes of the provisioning frame replay check.
// No dependencies; used by the parser, the window cells and the top level.
package pfrc_pkg;

  // Byte roles
  localparam logic [1:0] ROLE_HDR  = 2'd0;
  localparam logic [1:0] ROLE_NAME = 2'd1;
  localparam logic [1:0] ROLE_PASS = 2'd2;

  // Verdict codes
  localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
  localparam logic [2:0] VERDICT_MALFORM  = 3'd1;
  localparam logic [2:0] VERDICT_LIFETIME = 3'd2;
  localparam logic [2:0] VERDICT_REPLAY   = 3'd3;
  localparam logic [2:0] VERDICT_FULL     = 3'd4;
  localparam logic [2:0] VERDICT_FORGET   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_SSID = 2'd0;
  localparam logic [1:0] CFG_MAX_PWD  = 2'd1;

  // Largest lifetime in seconds
  localparam int unsigned MAX_LIFE_S = 60;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic replayed;
    logic found;
  } probe_t;

  localparam probe_t PROBE_FRESH = '{valid: 1'b1, replayed: 1'b0, found: 1'b0};
  localparam probe_t PROBE_NONE  = '{valid: 1'b0, replayed: 1'b0, found: 1'b0};

  // Per-byte result of the parser
  typedef struct packed {
    logic [1:0]  role;
    logic [2:0]  verdict;
    logic [31:0] ttl_ms;
    logic [63:0] nonce;
  } frame_res_t;

endpackage

// File: rtl/pfrc_parser.sv
// Frame parser: tracks the field being received and gives each byte's role
// and, on the final byte, the verdict before the replay scan. Uses pfrc_pkg.
module pfrc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          frame_byte_i,
  input  logic                frame_last_i,
  input  logic signed [63:0]  epoch_seconds_i,
  input  logic [5:0]          max_ssid_i,
  input  logic [6:0]          max_pwd_i,
  output pfrc_pkg::frame_res_t res_o
);

  // Parse phases
  localparam logic [2:0] PH_HEAD  = 3'd0;
  localparam logic [2:0] PH_LIFE  = 3'd1;
  localparam logic [2:0] PH_NONCE = 3'd2;
  localparam logic [2:0] PH_SLEN  = 3'd3;
  localparam logic [2:0] PH_SSID  = 3'd4;
  localparam logic [2:0] PH_PLEN  = 3'd5;
  localparam logic [2:0] PH_PASS  = 3'd6;
  localparam logic [2:0] PH_END   = 3'd7;

  // Frame error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MALFORM  = 2'd1;
  localparam logic [1:0] ERR_LIFETIME = 2'd2;

  localparam logic [6:0] POS_MAX = 7'd127;

  logic [2:0]  phase_q, phase_d;
  logic [6:0]  pos_q, pos_d;
  logic [1:0]  fmt_q, fmt_d;
  logic [63:0] exp_q, exp_d;
  logic [63:0] nonce_q, nonce_d;
  logic [6:0]  rem_q, rem_d;
  logic [1:0]  err_q, err_d;

  logic [6:0]  head;
  logic [2:0]  k_nonce;
  logic [2:0]  k_life;
  logic [1:0]  role;
  logic        forget;
  logic        complete;
  logic [63:0] diff;
  logic        life_bad;
  logic [2:0]  verdict;
  logic [31:0] ttl_ms;

  assign head    = (fmt_q == 2'd1) ? 7'd9 : 7'd2;
  assign k_nonce = 3'(pos_q - head);
  assign k_life  = 3'(pos_q - 7'd1);
  assign pos_d   = (pos_q < POS_MAX) ? pos_q + 7'd1 : pos_q;

  // Next parse state for the current byte
  always_comb begin
    phase_d = phase_q;
    fmt_d   = fmt_q;
    exp_d   = exp_q;
    nonce_d = nonce_q;
    rem_d   = rem_q;
    err_d   = err_q;
    role    = pfrc_pkg::ROLE_HDR;
    forget  = 1'b0;
    unique case (phase_q)
      PH_HEAD: begin
        fmt_d = (frame_byte_i == 8'd1) ? 2'd1 : (frame_byte_i == 8'd2) ? 2'd2 : 2'd0;
        if (fmt_d == 2'd0) begin
          err_d   = ERR_MALFORM;
          phase_d = PH_END;
        end else begin
          phase_d = PH_LIFE;
        end
      end
      PH_LIFE: begin
        forget = (pos_q == 7'd1) && (frame_byte_i == 8'd0);
        if (fmt_q == 2'd1) begin
          exp_d = exp_q | ({56'd0, frame_byte_i} << {k_life, 3'b000});
          if (pos_q >= 7'd8) phase_d = PH_NONCE;
        end else begin
          exp_d = {56'd0, frame_byte_i};
          if (((frame_byte_i == 8'd0) || (frame_byte_i > 8'(pfrc_pkg::MAX_LIFE_S)))
              && (err_q == ERR_NONE)) begin
            err_d = ERR_LIFETIME;
          end
          phase_d = PH_NONCE;
        end
      end
      PH_NONCE: begin
        nonce_d = nonce_q | ({56'd0, frame_byte_i} << {k_nonce, 3'b000});
        if (k_nonce == 3'd7) phase_d = PH_SLEN;
      end
      PH_SLEN: begin
        if ((frame_byte_i == 8'd0) || (frame_byte_i > {2'b00, max_ssid_i})) begin
          err_d   = ERR_MALFORM;
          phase_d = PH_END;
        end else begin
          rem_d   = frame_byte_i[6:0];
          phase_d = PH_SSID;
        end
      end
      PH_SSID: begin
        role  = pfrc_pkg::ROLE_NAME;
        rem_d = rem_q - 7'd1;
        if (rem_d == 7'd0) phase_d = PH_PLEN;
      end
      PH_PLEN: begin
        if (frame_byte_i > {1'b0, max_pwd_i}) begin
          err_d   = ERR_MALFORM;
          phase_d = PH_END;
        end else begin
          rem_d   = frame_byte_i[6:0];
          phase_d = (frame_byte_i == 8'd0) ? PH_END : PH_PASS;
        end
      end
      PH_PASS: begin
        role  = pfrc_pkg::ROLE_PASS;
        rem_d = rem_q - 7'd1;
        if (rem_d == 7'd0) phase_d = PH_END;
      end
      default: begin
        // bytes past the end of the frame
        err_d = ERR_MALFORM;
      end
    endcase
  end

  // Lifetime check and verdict for a final byte
  assign complete = (phase_d == PH_END) && (err_d != ERR_MALFORM);
  assign diff     = exp_d - $unsigned(epoch_seconds_i);
  assign life_bad = (epoch_seconds_i == 64'sd0) || (epoch_seconds_i < 64'sd0) ||
                    ($signed(exp_d) < epoch_seconds_i) ||
                    (diff > 64'(pfrc_pkg::MAX_LIFE_S));

  always_comb begin
    verdict = pfrc_pkg::VERDICT_ACCEPT;
    ttl_ms  = '0;
    if (forget) begin
      verdict = pfrc_pkg::VERDICT_FORGET;
    end else if (!complete) begin
      verdict = pfrc_pkg::VERDICT_MALFORM;
    end else if (fmt_d == 2'd1) begin
      if (life_bad) verdict = pfrc_pkg::VERDICT_LIFETIME;
      else ttl_ms = 32'({10'd0, diff[7:0]} * 18'd1000);
    end else if (err_d == ERR_LIFETIME) begin
      verdict = pfrc_pkg::VERDICT_LIFETIME;
    end else begin
      ttl_ms = 32'({10'd0, exp_d[7:0]} * 18'd1000);
    end
  end

  assign res_o = '{role: role, verdict: verdict, ttl_ms: ttl_ms, nonce: nonce_q};

  // Frame state; cleared after each final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      pos_q   <= '0;
      fmt_q   <= '0;
      exp_q   <= '0;
      nonce_q <= '0;
      rem_q   <= '0;
      err_q   <= ERR_NONE;
    end else if (accept_i) begin
      if (frame_last_i) begin
        phase_q <= PH_HEAD;
        pos_q   <= '0;
        fmt_q   <= '0;
        exp_q   <= '0;
        nonce_q <= '0;
        rem_q   <= '0;
        err_q   <= ERR_NONE;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        fmt_q   <= fmt_d;
        exp_q   <= exp_d;
        nonce_q <= nonce_d;
        rem_q   <= rem_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

// File: rtl/pfrc_cell.sv
// One replay window slot: holds a nonce, its deadline and a live flag, and
// updates the scan token passing through it. Uses pfrc_pkg.
module pfrc_cell #(
  parameter int unsigned SLOT_W   = 3,
  parameter int unsigned SLOT_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfrc_pkg::probe_t    probe_i,
  input  logic [SLOT_W-1:0]   avail_i,
  output pfrc_pkg::probe_t    probe_o,
  output logic [SLOT_W-1:0]   avail_o,
  input  logic [63:0]         nonce_i,
  input  logic [31:0]         now_i,
  input  logic                wr_en_i,
  input  logic [31:0]         wr_deadline_i
);

  logic [63:0]       nonce_q;
  logic [31:0]       deadline_q;
  logic              live_q;
  logic [31:0]       left;
  logic              live;
  logic              hit;
  pfrc_pkg::probe_t  probe_d, probe_q;
  logic [SLOT_W-1:0] avail_d, avail_q;

  // Live while the deadline is not behind the current time
  assign left = deadline_q - now_i;
  assign live = live_q && !left[31];
  assign hit  = live && (nonce_q == nonce_i);

  // Token update
  always_comb begin
    probe_d.valid    = probe_i.valid;
    probe_d.replayed = probe_i.replayed | hit;
    probe_d.found    = probe_i.found | !live;
    avail_d          = (probe_i.found || live) ? avail_i : SLOT_W'(SLOT_IDX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= pfrc_pkg::PROBE_NONE;
      live_q  <= 1'b0;
    end else begin
      probe_q <= probe_i.valid ? probe_d : pfrc_pkg::PROBE_NONE;
      if (wr_en_i) live_q <= 1'b1;
    end
  end

  // Slot contents and token payload
  always_ff @(posedge clk_i) begin
    avail_q <= avail_d;
    if (wr_en_i) begin
      nonce_q    <= nonce_i;
      deadline_q <= wr_deadline_i;
    end
  end

  assign probe_o = probe_q;
  assign avail_o = avail_q;

endmodule

// File: rtl/provisioning_frame_replay_check.sv
// Results: each accepted byte's result is loaded into the output register; for a
//   well-formed final byte it is loaded after the scan, grab and finish states, plus any result stall.
// Throughput: one byte per cycle while in_stall_o is low; a well-formed final byte holds off input
//   while the scan token walks once around the slot ring.
// Reset (rst_ni, async, active low): slots empty, parser at frame start,
//   registers at 32 and 64 bytes. No clearing pass.
module provisioning_frame_replay_check #(
  parameter int unsigned NONCE_SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // frame byte channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         frame_byte_i,
  input  logic               frame_last_i,
  input  logic [31:0]        time_ms_i,
  input  logic signed [63:0] epoch_seconds_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         byte_echo_o,
  output logic [1:0]         byte_role_o,
  output logic               frame_done_o,
  output logic [2:0]         verdict_o,
  output logic [31:0]        valid_until_ms_o,
  output logic [2:0]         slot_used_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);

  localparam int unsigned SlotW = (NONCE_SLOTS > 1) ? $clog2(NONCE_SLOTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NONCE_SLOTS - 1);

  // Control states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_GRAB = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [SlotW-1:0]     cnt_q, cnt_d;
  logic [SlotW-1:0]     start_q, start_d;
  logic [5:0]           max_ssid_q;
  logic [6:0]           max_pwd_q;

  logic                 in_fire;
  logic                 out_free;
  pfrc_pkg::frame_res_t pres;

  // frame context held across the scan
  logic [7:0]           ctx_byte_q;
  logic [1:0]           ctx_role_q;
  logic [63:0]          ctx_nonce_q;
  logic [31:0]          ctx_now_q;
  logic [31:0]          ctx_ttl_q;
  logic [31:0]          expires;

  // scan result
  pfrc_pkg::probe_t     res, res_q;
  logic [SlotW-1:0]     res_avail, res_avail_q;

  // output register
  logic                 out_valid_q;
  logic                 out_load;
  logic [7:0]           out_byte_d, out_byte_q;
  logic [1:0]           out_role_d, out_role_q;
  logic                 out_done_d, out_done_q;
  logic [2:0]           out_verdict_d, out_verdict_q;
  logic [31:0]          out_exp_d, out_exp_q;
  logic [2:0]           out_slot_d, out_slot_q;

  // slot ring
  pfrc_pkg::probe_t     probe_in  [NONCE_SLOTS];
  pfrc_pkg::probe_t     probe_out [NONCE_SLOTS];
  logic [SlotW-1:0]     avail_in  [NONCE_SLOTS];
  logic [SlotW-1:0]     avail_out [NONCE_SLOTS];
  logic [NONCE_SLOTS-1:0] probe_vld;
  logic                 inject;
  logic                 wr_en;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign expires    = ctx_now_q + ctx_ttl_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ssid_q <= 6'd32;
      max_pwd_q  <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pfrc_pkg::CFG_MAX_SSID: max_ssid_q <= cfg_data_i[5:0];
        pfrc_pkg::CFG_MAX_PWD:  max_pwd_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pfrc_parser u_parser (
    .clk_i,
    .rst_ni,
    .accept_i        (in_fire),
    .frame_byte_i,
    .frame_last_i,
    .epoch_seconds_i,
    .max_ssid_i      (max_ssid_q),
    .max_pwd_i       (max_pwd_q),
    .res_o           (pres)
  );

  // Ring of slot cells; the token enters at the scan start slot and leaves
  // the ring after the cell just before it
  assign inject = (state_q == ST_SCAN) && (cnt_q == '0);
  assign wr_en  = (state_q == ST_FIN) && out_free && !res_q.replayed && res_q.found;

  for (genvar i = 0; i < NONCE_SLOTS; i++) begin : g_cell
    localparam int unsigned Prev = (i == 0) ? NONCE_SLOTS - 1 : i - 1;

    assign probe_in[i] = (start_q != SlotW'(i)) ? probe_out[Prev] :
                         inject ? pfrc_pkg::PROBE_FRESH : pfrc_pkg::PROBE_NONE;
    assign avail_in[i] = avail_out[Prev];
    assign probe_vld[i] = probe_out[i].valid;

    pfrc_cell #(
      .SLOT_W   (SlotW),
      .SLOT_IDX (i)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .probe_i       (probe_in[i]),
      .avail_i       (avail_in[i]),
      .probe_o       (probe_out[i]),
      .avail_o       (avail_out[i]),
      .nonce_i       (ctx_nonce_q),
      .now_i         (ctx_now_q),
      .wr_en_i       (wr_en && (res_avail_q == SlotW'(i))),
      .wr_deadline_i (expires)
    );
  end

  // Pick up the token once it has passed every cell
  always_comb begin
    res       = pfrc_pkg::PROBE_NONE;
    res_avail = '0;
    for (int i = 0; i < NONCE_SLOTS; i++) begin
      if (probe_out[i].valid) begin
        res       = probe_out[i];
        res_avail = avail_out[i];
      end
    end
  end

  // Control sequencer and output register load
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    start_d       = start_q;
    out_load      = 1'b0;
    out_byte_d    = pres.nonce[7:0];
    out_role_d    = pres.role;
    out_done_d    = frame_last_i;
    out_verdict_d = pfrc_pkg::VERDICT_ACCEPT;
    out_exp_d     = '0;
    out_slot_d    = '0;
    unique case (state_q)
      ST_IDLE: begin
        out_byte_d = frame_byte_i;
        if (in_fire) begin
          if (frame_last_i && (pres.verdict == pfrc_pkg::VERDICT_ACCEPT)) begin
            state_d = ST_SCAN;
            cnt_d   = '0;
          end else begin
            out_load      = 1'b1;
            out_verdict_d = frame_last_i ? pres.verdict : pfrc_pkg::VERDICT_ACCEPT;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastSlot) state_d = ST_GRAB;
      end
      ST_GRAB: begin
        state_d = ST_FIN;
      end
      default: begin
        out_byte_d = ctx_byte_q;
        out_role_d = ctx_role_q;
        out_done_d = 1'b1;
        if (res_q.replayed) begin
          out_verdict_d = pfrc_pkg::VERDICT_REPLAY;
        end else if (!res_q.found) begin
          out_verdict_d = pfrc_pkg::VERDICT_FULL;
        end else begin
          out_exp_d  = expires;
          out_slot_d = 3'(res_avail_q);
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (wr_en) start_d = (res_avail_q == LastSlot) ? '0 : res_avail_q + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= pfrc_pkg::PROBE_NONE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_GRAB) res_q <= res;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ctx_byte_q  <= frame_byte_i;
      ctx_role_q  <= pres.role;
      ctx_nonce_q <= pres.nonce;
      ctx_now_q   <= time_ms_i;
      ctx_ttl_q   <= pres.ttl_ms;
    end
    if (state_q == ST_GRAB) res_avail_q <= res_avail;
    if (out_load) begin
      out_byte_q    <= out_byte_d;
      out_role_q    <= out_role_d;
      out_done_q    <= out_done_d;
      out_verdict_q <= out_verdict_d;
      out_exp_q     <= out_exp_d;
      out_slot_q    <= out_slot_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_echo_o      = out_byte_q;
  assign byte_role_o      = out_role_q;
  assign frame_done_o     = out_done_q;
  assign verdict_o        = out_verdict_q;
  assign valid_until_ms_o = out_exp_q;
  assign slot_used_o      = out_slot_q;

  // Assertions
  `include "assert_macros.svh"

  `PFRC_ASSERT(a_one_token, $onehot0(probe_vld), "more than one scan token in the ring")
  `PFRC_ASSERT_IMP(a_token_home, state_q == ST_GRAB, $onehot(probe_vld), "scan token lost")
  `PFRC_ASSERT_IMP(a_mid_frame_quiet, out_valid_o && !frame_done_o, (verdict_o == pfrc_pkg::VERDICT_ACCEPT) && (valid_until_ms_o == '0) && (slot_used_o == '0), "verdict fields set before the final byte")

endmodule

// File: tb/sv/pfrc_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the provisioning frame replay check: per-byte parser and
// replay window predictor plus the queue of awaited results. Depends on pfrc_pkg.
package pfrc_tb_pkg;
  import pfrc_pkg::*;

  localparam int SLOTS = 8;

  // Format selector values as they appear in the first frame byte
  localparam logic [7:0] FRAME_BYTE_EPOCH = 8'd1;
  localparam logic [7:0] FRAME_BYTE_TTL   = 8'd2;

  // Frame fault codes held while a frame is parsed
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_MALFORM  = 2'd1;
  localparam logic [1:0] FAULT_LIFETIME = 2'd2;

  typedef enum logic [1:0] {FMT_NONE, FMT_EPOCH, FMT_TTL} frame_fmt_e;

  typedef enum logic [2:0] {
    P_HEADER, P_LIFETIME, P_NONCE, P_NAME_LEN, P_NAME, P_PWD_LEN, P_PWD, P_TAIL
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]  echo;
    logic [1:0]  role;
    logic        done;
    logic [2:0]  verdict;
    logic [31:0] expires_ms;
    logic [2:0]  slot;
  } frame_result_t;

  class frame_scoreboard;
    // replay window
    logic [63:0]   nonce_mem [SLOTS];
    logic [31:0]   deadline_mem [SLOTS];
    bit            live_mem [SLOTS];
    int unsigned   scan_from;
    // parser
    logic [6:0]    pos;
    frame_fmt_e    fmt;
    logic [63:0]   expiry_acc;
    logic [63:0]   nonce_acc;
    logic [6:0]    remaining;
    logic [1:0]    fault;
    parse_phase_e  phase;
    // registers
    logic [5:0]    ssid_limit;
    logic [6:0]    pwd_limit;
    frame_result_t awaited_q[$];
    int unsigned   mismatches;

    function new();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        nonce_mem[i] = '0;
        deadline_mem[i] = '0;
        live_mem[i] = 1'b0;
      end
      scan_from = 0;
      ssid_limit = 6'd32;
      pwd_limit = 7'd64;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = '0;
      fmt = FMT_NONE;
      expiry_acc = '0;
      nonce_acc = '0;
      remaining = '0;
      fault = FAULT_NONE;
      phase = P_HEADER;
    endfunction

    function void set_limit(logic [1:0] idx, logic [6:0] value);
      if (idx == CFG_MAX_SSID) ssid_limit = value[5:0];
      else if (idx == CFG_MAX_PWD) pwd_limit = value;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    // Step the parser on one accepted byte and queue the result it causes
    function void note_input(logic [7:0] b, logic last, logic [31:0] now, logic [63:0] wall);
      int            head, k, off, idx, avail;
      bit            forget, complete, replayed, live;
      logic [31:0]   ttl_ms, dl;
      logic [63:0]   span;
      frame_result_t r;
      head = (fmt == FMT_EPOCH) ? 9 : 2;
      forget = 1'b0;
      r = '0;
      r.echo = b;
      r.done = last;
      r.role = ROLE_HDR;
      r.verdict = VERDICT_ACCEPT;
      case (phase)
        P_HEADER: begin
          fmt = (b == FRAME_BYTE_EPOCH) ? FMT_EPOCH : (b == FRAME_BYTE_TTL) ? FMT_TTL : FMT_NONE;
          if (fmt == FMT_NONE) begin
            fault = FAULT_MALFORM;
            phase = P_TAIL;
          end else begin
            phase = P_LIFETIME;
          end
        end
        P_LIFETIME: begin
          if (pos == 7'd1 && b == 8'd0) forget = 1'b1;
          if (fmt == FMT_EPOCH) begin
            k = (int'(pos) - 1) & 7;
            expiry_acc = expiry_acc | (64'(b) << (8 * k));
            if (pos >= 7'd8) phase = P_NONCE;
          end else begin
            expiry_acc = 64'(b);
            if ((b == 8'd0 || b > MAX_LIFE_S) && fault == FAULT_NONE) fault = FAULT_LIFETIME;
            phase = P_NONCE;
          end
        end
        P_NONCE: begin
          k = (int'(pos) - head) & 7;
          nonce_acc = nonce_acc | (64'(b) << (8 * k));
          if (k == 7) phase = P_NAME_LEN;
        end
        P_NAME_LEN: begin
          if (b == 8'd0 || b > ssid_limit) begin
            fault = FAULT_MALFORM;
            phase = P_TAIL;
          end else begin
            remaining = b[6:0];
            phase = P_NAME;
          end
        end
        P_NAME: begin
          r.role = ROLE_NAME;
          remaining = remaining - 7'd1;
          if (remaining == 7'd0) phase = P_PWD_LEN;
        end
        P_PWD_LEN: begin
          if (b > pwd_limit) begin
            fault = FAULT_MALFORM;
            phase = P_TAIL;
          end else begin
            remaining = b[6:0];
            phase = (b == 8'd0) ? P_TAIL : P_PWD;
          end
        end
        P_PWD: begin
          r.role = ROLE_PASS;
          remaining = remaining - 7'd1;
          if (remaining == 7'd0) phase = P_TAIL;
        end
        default: fault = FAULT_MALFORM;
      endcase
      if (pos < 7'd127) pos = pos + 7'd1;

      if (last) begin
        complete = (phase == P_TAIL) && (fault != FAULT_MALFORM);
        ttl_ms = '0;
        if (forget) begin
          r.verdict = VERDICT_FORGET;
        end else if (!complete) begin
          r.verdict = VERDICT_MALFORM;
        end else if (fmt == FMT_EPOCH) begin
          span = expiry_acc - wall;
          if (wall == 64'd0 || wall[63] || $signed(expiry_acc) < $signed(wall) ||
              span > MAX_LIFE_S)
            r.verdict = VERDICT_LIFETIME;
          else
            ttl_ms = span[31:0] * 32'd1000;
        end else if (fault == FAULT_LIFETIME) begin
          r.verdict = VERDICT_LIFETIME;
        end else begin
          ttl_ms = expiry_acc[31:0] * 32'd1000;
        end

        // Window scan from the slot after the last one taken
        if (r.verdict == VERDICT_ACCEPT) begin
          replayed = 1'b0;
          avail = -1;
          for (off = 0; off < SLOTS && !replayed; off++) begin
            idx = (scan_from + off) % SLOTS;
            dl = deadline_mem[idx] - now;
            live = live_mem[idx] && !dl[31];
            if (live && nonce_mem[idx] == nonce_acc) replayed = 1'b1;
            else if (!live && avail < 0) avail = idx;
          end
          if (replayed) begin
            r.verdict = VERDICT_REPLAY;
          end else if (avail < 0) begin
            r.verdict = VERDICT_FULL;
          end else begin
            r.expires_ms = now + ttl_ms;
            r.slot = 3'(avail);
            nonce_mem[avail] = nonce_acc;
            deadline_mem[avail] = r.expires_ms;
            live_mem[avail] = 1'b1;
            scan_from = (avail + 1) % SLOTS;
          end
        end
        clear_frame();
      end
      awaited_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one result transaction with the oldest awaited one
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (awaited_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = awaited_q.pop_front();
      compare_field("byte_echo", want.echo, got.echo);
      compare_field("byte_role", want.role, got.role);
      compare_field("frame_done", want.done, got.done);
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("valid_until_ms", want.expires_ms, got.expires_ms);
      compare_field("slot_used", want.slot, got.slot);
    endfunction
  endclass

endpackage

// File: tb/sv/provisioning_frame_replay_check_tb.sv
`timescale 1ns / 100ps
// Top of the provisioning frame replay check testbench: clock, reset, frame
// stimulus, result stall and monitor. Depends on pfrc_pkg and pfrc_tb_pkg.
module provisioning_frame_replay_check_tb;
  import pfrc_pkg::*;
  import pfrc_tb_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASES       = 6;
  localparam int POOL         = 12;
  localparam int LIMIT_NS     = 5_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         frame_byte_i = '0;
  logic               frame_last_i = 1'b0;
  logic [31:0]        time_ms_i = '0;
  logic signed [63:0] epoch_seconds_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         byte_echo_o;
  logic [1:0]         byte_role_o;
  logic               frame_done_o;
  logic [2:0]         verdict_o;
  logic [31:0]        valid_until_ms_o;
  logic [2:0]         slot_used_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_MAX_SSID;
  logic [6:0]         cfg_data_i = '0;

  frame_scoreboard sb;
  logic [7:0]      frame_q[$];
  logic [63:0]     nonce_pool [POOL];
  logic [31:0]     clock_ms = '0;
  int unsigned     items_sent = 0;
  int unsigned     ssid_max = 32;
  int unsigned     pwd_max = 64;
  int unsigned     stall_left = 0;
  bit              idling = 1'b1;
  int unsigned     ssid_plan [PHASES] = '{12, 1, 32, 3, 1, 32};
  int unsigned     pwd_plan [PHASES] = '{5, 0, 64, 1, 64, 0};

  provisioning_frame_replay_check #(
    .NONCE_SLOTS(SLOTS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .frame_byte_i    (frame_byte_i),
    .frame_last_i    (frame_last_i),
    .time_ms_i       (time_ms_i),
    .epoch_seconds_i (epoch_seconds_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_echo_o     (byte_echo_o),
    .byte_role_o     (byte_role_o),
    .frame_done_o    (frame_done_o),
    .verdict_o       (verdict_o),
    .valid_until_ms_o(valid_until_ms_o),
    .slot_used_o     (slot_used_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result side: check every accepted transaction, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({byte_echo_o, byte_role_o, frame_done_o, verdict_o,
                       valid_until_ms_o, slot_used_o});
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(1, 10);
    end
  end

  // Offer one byte; returns at the edge that accepts it
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] now,
                           input logic [63:0] wall);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_byte_i <= b;
    frame_last_i <= last;
    time_ms_i <= now;
    epoch_seconds_i <= wall;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b, last, now, wall);
    items_sent++;
  endtask

  // Clocks matter only on the last byte; earlier bytes carry noise there
  task automatic send_frame(input logic [31:0] now, input logic [63:0] wall);
    int i;
    for (i = 0; i < frame_q.size(); i++) begin
      if (i == frame_q.size() - 1) send_byte(frame_q[i], 1'b1, now, wall);
      else send_byte(frame_q[i], 1'b0, $urandom(), {$urandom(), $urandom()});
    end
  endtask

  // Hold the frame channel until every awaited result is in
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(idx, value);
  endtask

  task automatic set_limits(input int unsigned ssid, input int unsigned pwd);
    drain();
    write_reg(CFG_MAX_SSID, 7'(ssid));
    write_reg(CFG_MAX_PWD, 7'(pwd));
    cfg_valid_i <= 1'b0;
    ssid_max = ssid;
    pwd_max = pwd;
  endtask

  function automatic void push_le64(input logic [63:0] v);
    int i;
    for (i = 0; i < 8; i++) frame_q.push_back(v[8 * i +: 8]);
  endfunction

  // Mostly short fields, now and then the limit
  function automatic int unsigned pick_len(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return hi;
    if (r == 1) return $urandom_range(lo, hi);
    return $urandom_range(lo, (hi < 4) ? hi : 4);
  endfunction

  // One frame: mostly well formed, some forget requests, some broken
  task automatic random_frame();
    int unsigned pick, slen, plen, slen_at, cut;
    logic [63:0] wall, expiry, nonce;
    logic [7:0]  ttl;
    bit          epoch_fmt;
    frame_q.delete();
    pick = $urandom_range(0, 99);
    epoch_fmt = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 4000);
    case ($urandom_range(0, 9))
      0: wall = 64'($urandom_range(1, 100));
      1: wall = 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 100));
      default: wall = {1'b0, 31'($urandom()), 32'($urandom())} | 64'd1;
    endcase
    expiry = wall + 64'($urandom_range(0, MAX_LIFE_S));
    ttl = 8'($urandom_range(1, MAX_LIFE_S));
    // lifetime faults
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 4))
        0: expiry = wall + 64'($urandom_range(MAX_LIFE_S + 1, 1000));
        1: expiry = wall - 64'($urandom_range(1, 1000));
        2: wall = 64'd0;
        3: wall[63] = 1'b1;
        default: ttl = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(MAX_LIFE_S + 1, 255));
      endcase
    end
    if ($urandom_range(0, 99) < 65) nonce = nonce_pool[$urandom_range(0, POOL - 1)];
    else nonce = {$urandom(), $urandom()};

    if (pick < 10) begin
      // forget request, sometimes behind a bad format byte
      frame_q.push_back((pick < 8) ? 8'($urandom_range(1, 2)) : 8'($urandom()));
      frame_q.push_back(8'd0);
    end else begin
      frame_q.push_back(epoch_fmt ? FRAME_BYTE_EPOCH : FRAME_BYTE_TTL);
      if (epoch_fmt) push_le64(expiry);
      else frame_q.push_back(ttl);
      push_le64(nonce);
      slen = pick_len(1, ssid_max);
      plen = pick_len(0, pwd_max);
      slen_at = frame_q.size();
      frame_q.push_back(8'(slen));
      repeat (slen) frame_q.push_back(8'($urandom()));
      frame_q.push_back(8'(plen));
      repeat (plen) frame_q.push_back(8'($urandom()));
      if (pick >= 75) begin
        if ($urandom_range(0, 39) == 0) begin
          // long tail past the saturation of the position counter
          repeat ($urandom_range(120, 150)) frame_q.push_back(8'($urandom()));
        end else begin
          case ($urandom_range(0, 5))
            0: begin
              cut = $urandom_range(1, frame_q.size() - 1);
              while (frame_q.size() > cut) void'(frame_q.pop_back());
            end
            1: repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom()));
            2: frame_q[0] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(3, 255));
            3: frame_q[slen_at] = ($urandom_range(0, 1) == 0) ? 8'd0 :
                                  8'($urandom_range(ssid_max + 1, 255));
            4: frame_q[slen_at + 1 + slen] = 8'($urandom_range(pwd_max + 1, 255));
            default: frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom());
          endcase
        end
      end
    end
    send_frame(clock_ms, wall);
  endtask

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int i, ph;
    int unsigned target;
    sb = new();
    nonce_pool[0] = '0;
    nonce_pool[1] = '1;
    for (i = 2; i < POOL; i++) nonce_pool[i] = {$urandom(), $urandom()};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: forget requests, bad format, trailing byte, max TTL with a
    // wrapping deadline, short frame
    frame_q = '{FRAME_BYTE_EPOCH, 8'd0};
    send_frame(32'd0, 64'h8000_0000_0000_0000);
    frame_q = '{FRAME_BYTE_TTL, 8'd0};
    send_frame(32'hffff_ffff, 64'h7fff_ffff_ffff_ffff);
    frame_q = '{8'd0};
    send_frame(32'd5, 64'd1);
    frame_q = '{8'hff, 8'd0};
    send_frame(32'd6, 64'd1);
    frame_q.delete();
    frame_q.push_back(FRAME_BYTE_TTL);
    frame_q.push_back(8'(MAX_LIFE_S));
    push_le64('1);
    frame_q.push_back(8'd1);
    frame_q.push_back(8'd0);
    frame_q.push_back(8'd0);
    send_frame(32'hffff_ffff, 64'd1);
    frame_q = '{FRAME_BYTE_TTL, 8'd61};
    send_frame(32'd7, 64'd1);

    // Random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      set_limits(ssid_plan[ph], pwd_plan[ph]);
      idling = (ph != 2) && (ph != PHASES - 1);
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) random_frame();
    end

    drain();
    repeat (SLOTS + 4) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
